>>> hdl/astr_pkg.sv
// shared types and constants for the angle sensor speed tracker
// no dependencies
package astr_pkg;

  // electrical counts per turn and index width
  localparam int unsigned ELEC_COUNTS = 8192;
  localparam int unsigned ELEC_BITS   = $clog2(ELEC_COUNTS);
  localparam int unsigned HALF_COUNTS = ELEC_COUNTS / 2;

  // raw word layout
  localparam logic [15:0] WORD_FAIL = 16'hFFFF;
  localparam int unsigned ANGLE_W   = 15;

  // speed scaling: 1e6 * 2pi * 2^24, shifted down by counts * 256
  localparam logic [47:0] SPEED_NUM   = 48'd105414357000000;
  localparam int unsigned SPEED_SHIFT = ELEC_BITS + 8;

  // rpm scaling
  localparam logic [16:0] RPM_NUM = 17'd95493;
  localparam logic [13:0] RPM_DEN = 14'd10000;

  // serial divider sizes
  localparam int unsigned DIV_W = 56;
  localparam int unsigned DVS_W = 24;
  localparam int unsigned CNT_W = $clog2(DIV_W);

  // register indexes
  localparam logic [1:0] REG_INTERVAL   = 2'd0;
  localparam logic [1:0] REG_POLE_PAIRS = 2'd1;

  // result status codes
  typedef enum logic [1:0] {
    ST_NEW   = 2'd0,
    ST_STALE = 2'd1,
    ST_FAIL  = 2'd2
  } status_e;

  // classified item between front and back
  typedef struct packed {
    status_e              kind;
    logic [ANGLE_W-1:0]   angle;
  } item_t;

  // divider request
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  // divider response
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> hdl/astr_front.sv
// front end: classifies raw sensor words and queues them for the back end
// depends on astr_pkg
module astr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     raw_word_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            q_valid_o,
  output astr_pkg::item_t q_item_o,
  input  logic            q_pop_i
);
  import astr_pkg::*;

  item_t       entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  item_t       item;
  logic        push;

  // classify the incoming word
  always_comb begin
    item.angle = raw_word_i[ANGLE_W-1:0];
    if (raw_word_i == WORD_FAIL) begin
      item.kind = ST_FAIL;
    end else if (!raw_word_i[15]) begin
      item.kind = ST_STALE;
    end else begin
      item.kind = ST_NEW;
    end
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = entry_q[rd_ptr_q];

  // two-entry queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      case ({push, q_pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> hdl/astr_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on astr_pkg
module astr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  astr_pkg::div_req_t req_i,
  output astr_pkg::div_rsp_t rsp_o
);
  import astr_pkg::*;

  logic [DIV_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   rem_sh, diff;

  // trial subtract
  assign rem_sh = {rem_q, quo_q[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      if (!diff[DVS_W]) begin
        rem_q <= diff[DVS_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DVS_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/astr_back.sv
// back end: angle tracking, speed, filter and rpm sequencer with output register
// depends on astr_pkg and astr_div
module astr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        interval_i,
  input  logic [7:0]         pole_pairs_i,
  input  logic               q_valid_i,
  input  astr_pkg::item_t    q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [14:0]        mech_angle_o,
  output logic [12:0]        elec_index_o,
  output logic signed [47:0] speed_now_o,
  output logic signed [47:0] speed_filtered_o,
  output logic signed [47:0] rpm_o,
  output logic [15:0]        fail_count_o
);
  import astr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MLO, S_MHI, S_SDIV_GO, S_SDIV, S_FDIV_GO, S_FDIV,
    S_RDIV_GO, S_RDIV, S_OUT
  } state_e;

  state_e                 state_q;
  status_e                status_q;
  logic                   phase_q, neg_q;
  logic [ELEC_BITS-1:0]   prev_q;
  logic [ANGLE_W-1:0]     mech_q;
  logic signed [47:0]     spd_q, filt_q, rpm_q;
  logic [15:0]            fail_q;
  logic [47:0]            mul_a_q;
  logic [16:0]            mul_b_q;
  logic [63:0]            acc_q;
  logic                   out_valid_q;
  logic [DIV_W-1:0]       tdiv_q;
  logic [3:0]             trem_q;
  logic [3:0]             tcnt_q;

  div_req_t               div_req;
  div_rsp_t               div_rsp;
  logic [ELEC_BITS-1:0]   idx;
  logic signed [ELEC_BITS+1:0] d_raw, d_wrap;
  logic [ELEC_BITS+1:0]   d_mag;
  logic signed [52:0]     t_sum;
  logic [52:0]            t_mag;
  logic [7:0]             pp_eff;
  logic [47:0]            quo48, quo_signed;
  logic [40:0]            prod;
  logic [7:0]             tcur, tsub;
  logic [15:0]            tprod;
  logic [3:0]             tdig;
  logic [DIV_W-1:0]       tquo;
  logic [47:0]            filt_signed;

  astr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // index difference wrapped to half a turn
  assign idx   = q_item_i.angle[ELEC_BITS-1:0];
  assign d_raw = $signed({2'b00, idx}) - $signed({2'b00, prev_q});
  always_comb begin
    if (d_raw > $signed((ELEC_BITS+2)'(HALF_COUNTS))) begin
      d_wrap = d_raw - $signed((ELEC_BITS+2)'(ELEC_COUNTS));
    end else if (d_raw < -$signed((ELEC_BITS+2)'(HALF_COUNTS))) begin
      d_wrap = d_raw + $signed((ELEC_BITS+2)'(ELEC_COUNTS));
    end else begin
      d_wrap = d_raw;
    end
  end
  assign d_mag = d_wrap[ELEC_BITS+1] ? (ELEC_BITS+2)'(-d_wrap) : d_wrap;

  // filter sum 9*f + s
  assign t_sum = ($signed({{5{filt_q[47]}}, filt_q}) <<< 3)
               + $signed({{5{filt_q[47]}}, filt_q})
               + $signed({{5{spd_q[47]}}, spd_q});
  assign t_mag = t_sum[52] ? 53'(-t_sum) : t_sum;

  // divide by ten one nibble per cycle: digit = (r*16 + nibble) * 205 >> 11,
  // exact since the partial value stays below 160
  assign tcur  = {trem_q, tdiv_q[DIV_W-1 -: 4]};
  assign tprod = {8'd0, tcur} * 16'd205;
  assign tdig  = tprod[14:11];
  assign tsub  = tcur - {1'b0, tdig, 3'b000} - {3'b000, tdig, 1'b0};
  assign tquo  = {tdiv_q[DIV_W-5:0], tdig};
  assign filt_signed = neg_q ? (48'd0 - tquo[47:0]) : tquo[47:0];

  assign pp_eff     = (pole_pairs_i == 8'd0) ? 8'd1 : pole_pairs_i;
  assign quo48      = div_rsp.quotient[47:0];
  assign quo_signed = neg_q ? (48'd0 - quo48) : quo48;

  // partial product, low or high half of operand a
  assign prod = (state_q == S_MLO) ? (mul_a_q[23:0] * mul_b_q)
                                   : (mul_a_q[47:24] * mul_b_q);

  // divider operand selection
  always_comb begin
    div_req = '0;
    case (state_q)
      S_SDIV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(acc_q[63:SPEED_SHIFT]);
        div_req.divisor  = DVS_W'(interval_i);
      end
      S_RDIV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = acc_q[DIV_W-1:0];
        div_req.divisor  = DVS_W'(RPM_DEN) * DVS_W'(pp_eff);
      end
      default: div_req = '0;
    endcase
  end

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  // payload-free working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        mul_a_q <= SPEED_NUM;
        mul_b_q <= 17'(d_mag);
        neg_q   <= d_wrap[ELEC_BITS+1];
      end
      S_MLO:     acc_q <= 64'(prod);
      S_MHI:     acc_q <= acc_q + 64'({prod, 24'd0});
      S_FDIV_GO: begin
        neg_q  <= t_sum[52];
        tdiv_q <= DIV_W'(t_mag);
        trem_q <= 4'd0;
        tcnt_q <= 4'd0;
      end
      S_FDIV: begin
        tdiv_q <= tquo;
        trem_q <= tsub[3:0];
        tcnt_q <= tcnt_q + 4'd1;
        if (tcnt_q == 4'(DIV_W/4 - 1)) begin
          mul_a_q <= tquo[47:0];
          mul_b_q <= RPM_NUM;
        end
      end
      default: ;
    endcase
  end

  // sequencer, tracker state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      status_q         <= ST_NEW;
      phase_q          <= 1'b0;
      prev_q           <= '0;
      mech_q           <= '0;
      spd_q            <= '0;
      filt_q           <= '0;
      rpm_q            <= '0;
      fail_q           <= '0;
      out_valid_q      <= 1'b0;
      status_o         <= '0;
      mech_angle_o     <= '0;
      elec_index_o     <= '0;
      speed_now_o      <= '0;
      speed_filtered_o <= '0;
      rpm_o            <= '0;
      fail_count_o     <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            status_q <= q_item_i.kind;
            if (q_item_i.kind == ST_NEW && interval_i != 16'd0) begin
              phase_q <= 1'b0;
              state_q <= S_MLO;
            end else begin
              state_q <= S_OUT;
            end
            case (q_item_i.kind)
              ST_FAIL: fail_q <= fail_q + 16'd1;
              ST_NEW: begin
                mech_q <= q_item_i.angle;
                prev_q <= idx;
              end
              default: ;
            endcase
          end
        end
        S_MLO: state_q <= S_MHI;
        S_MHI: state_q <= phase_q ? S_RDIV_GO : S_SDIV_GO;
        S_SDIV_GO: state_q <= S_SDIV;
        S_SDIV: begin
          if (div_rsp.done) begin
            spd_q   <= quo_signed;
            state_q <= S_FDIV_GO;
          end
        end
        S_FDIV_GO: state_q <= S_FDIV;
        S_FDIV: begin
          if (tcnt_q == 4'(DIV_W/4 - 1)) begin
            filt_q  <= filt_signed;
            phase_q <= 1'b1;
            state_q <= S_MLO;
          end
        end
        S_RDIV_GO: state_q <= S_RDIV;
        S_RDIV: begin
          if (div_rsp.done) begin
            rpm_q   <= quo_signed;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q      <= 1'b1;
            status_o         <= status_q;
            mech_angle_o     <= mech_q;
            elec_index_o     <= prev_q;
            speed_now_o      <= spd_q;
            speed_filtered_o <= filt_q;
            rpm_o            <= rpm_q;
            fail_count_o     <= fail_q;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/angle_sensor_speed_tracker_unit.sv
// Angle sensor speed tracker. Input channel: raw_word_i with in_valid_i /
// in_ready_o; a transaction moves one raw 16-bit sensor word. Output
// channel: out_valid_o / out_ready_i; each input word yields exactly one
// result transaction carrying status, held angle and index, raw and
// filtered speed, rpm and the failure count.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 sample interval, 1 pole pairs) in the same edge. The user must
// write only while idle; the block itself does not enforce this.
// Failure, stale and zero-interval words skip the arithmetic and go to
// the output register. A new angle with a nonzero interval runs two
// partial-product steps and a serial divider pass for the speed, a divide
// by ten for the filter, then two partial-product steps and a divider
// pass for the rpm. The sequencer takes the next word only when done.
// A two-entry queue separates the word classifier from the sequencer, so
// up to two input words are still taken while the sequencer works or the
// result waits. If the receiver stalls, the result holds in the output
// register and the sequencer waits with the next finished result.
// Reset clears all tracker state; pole pairs resets to one, interval to 0.
// depends on astr_pkg, astr_front, astr_back
module angle_sensor_speed_tracker_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        raw_word_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [14:0]        mech_angle_o,
  output logic [12:0]        elec_index_o,
  output logic signed [47:0] speed_now_o,
  output logic signed [47:0] speed_filtered_o,
  output logic signed [47:0] rpm_o,
  output logic [15:0]        fail_count_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  import astr_pkg::*;

  logic [15:0] interval_q;
  logic [7:0]  pole_pairs_q;
  logic        q_valid, q_pop;
  item_t       q_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q   <= 16'd0;
      pole_pairs_q <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INTERVAL:   interval_q   <= cfg_data_i;
        REG_POLE_PAIRS: pole_pairs_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  astr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .raw_word_i (raw_word_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  astr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .interval_i       (interval_q),
    .pole_pairs_i     (pole_pairs_q),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .mech_angle_o     (mech_angle_o),
    .elec_index_o     (elec_index_o),
    .speed_now_o      (speed_now_o),
    .speed_filtered_o (speed_filtered_o),
    .rpm_o            (rpm_o),
    .fail_count_o     (fail_count_o)
  );

endmodule

>>> hdl/astr_checker.sv
// port-level checks for the angle sensor speed tracker, bound to the top level
// depends on astr_pkg and angle_sensor_speed_tracker_unit
module astr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         status_o,
  input logic [14:0]        mech_angle_o,
  input logic [12:0]        elec_index_o,
  input logic [15:0]        fail_count_o
);
  import astr_pkg::*;

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fail_count_o))
    else $error("stalled result dropped or changed");

  // index always tracks the low bits of the held angle
  a_idx_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mech_angle_o[ELEC_BITS-1:0] == elec_index_o)
    else $error("electrical index does not match angle");

  // status is a defined code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_NEW || status_o == ST_STALE || status_o == ST_FAIL))
    else $error("undefined status code");

endmodule

bind angle_sensor_speed_tracker_unit astr_checker u_astr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .mech_angle_o (mech_angle_o),
  .elec_index_o (elec_index_o),
  .fail_count_o (fail_count_o)
);
